// ===== rtl/lfsp_pkg.sv =====
// Shared types, widths and constants of the lens flare sprite placer.
// Used by every module in rtl/; depends on nothing else.
package lfsp_pkg;

	localparam int ELEM_DEPTH = 16;
	localparam int ELEM_AW    = $clog2(ELEM_DEPTH);
	localparam int CNT_W      = $clog2(ELEM_DEPTH + 1);

	localparam int GEO_W  = 32;
	localparam int LOOK_W = 35;

	localparam int SQ_IN_W  = 26;
	localparam int SQ_OUT_W = 13;
	localparam int SQ_STEPS = SQ_OUT_W;

	localparam int DIV_NW = 26;
	localparam int DIV_DW = 13;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	localparam logic [CFG_IW-1:0] REG_CENTER_X   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_CENTER_Y   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_SCALE_PX   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_MAX_PX     = 3'd3;
	localparam logic [CFG_IW-1:0] REG_HEIGHT_RAT = 3'd4;
	localparam logic [CFG_IW-1:0] REG_ELEM_COUNT = 3'd5;

	localparam logic [11:0] RST_CENTER_X = 12'd320;
	localparam logic [11:0] RST_CENTER_Y = 12'd240;
	localparam logic [11:0] RST_SCALE_PX = 12'd192;
	localparam logic [11:0] RST_MAX_PX   = 12'd192;
	localparam logic [15:0] RST_HEIGHT   = 16'd256;

	localparam logic KIND_RENDER = 1'b0;
	localparam logic KIND_LOAD   = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [11:0] light_x;
		logic [11:0] light_y;
		logic [3:0]  element_index;
		logic [15:0] element_distance;
		logic [15:0] element_size;
		logic [31:0] element_colour;
		logic [2:0]  element_texture;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] quad_x;
		logic signed [15:0] quad_y;
		logic [11:0]        quad_width;
		logic [15:0]        quad_height;
		logic [31:0]        quad_colour;
		logic [2:0]         quad_texture;
		logic               drawn;
		logic               last;
	} out_item_t;

endpackage

// ===== rtl/lens_flare_sprite_placer_top.sv =====
// Top level of the lens flare sprite placer: sequencer, arithmetic datapath,
// configuration registers. Depends on lfsp_pkg, lfsp_elem_mem, lfsp_isqrt, lfsp_div.
//
//  channel | signals                         | direction | transfer when
//  --------+---------------------------------+-----------+----------------------
//  in      | in_valid, in_ready, in_data     | sink      | in_valid & in_ready
//  out     | out_valid, out_ready, out_data  | source    | out_valid & out_ready
//  cfg     | cfg_we, cfg_index, cfg_wdata    | sink      | cfg_we
//
// A load transfer writes the element table in the same cycle; in_ready returns at once.
// A render first sets up with two 13-step square roots (corner distance, then light
// distance) and the falloff product, then handles one element at a time, paced by
// out_ready and by the 26-step divider pair for width and alpha (the dividers are
// skipped when the corner distance is zero).
// One item is in flight at a time: in_ready is high only when the sequencer is idle.
// A stalled result is held in the output register until out_ready takes it.
// Reset clears the sequencer and loads the register defaults; the table is not cleared.
module lens_flare_sprite_placer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  lfsp_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lfsp_pkg::out_item_t         out_data,
	input  logic                        cfg_we,
	input  logic [lfsp_pkg::CFG_IW-1:0] cfg_index,
	input  logic [lfsp_pkg::CFG_DW-1:0] cfg_wdata
);
	import lfsp_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQC  = 4'd1;
	localparam logic [3:0] S_RTC  = 4'd2;
	localparam logic [3:0] S_SQL  = 4'd3;
	localparam logic [3:0] S_RTL  = 4'd4;
	localparam logic [3:0] S_FS   = 4'd5;
	localparam logic [3:0] S_RD   = 4'd6;
	localparam logic [3:0] S_M1   = 4'd7;
	localparam logic [3:0] S_M2   = 4'd8;
	localparam logic [3:0] S_M3   = 4'd9;
	localparam logic [3:0] S_DIV  = 4'd10;
	localparam logic [3:0] S_WID  = 4'd11;
	localparam logic [3:0] S_HGT  = 4'd12;
	localparam logic [3:0] S_FORM = 4'd13;
	localparam logic [3:0] S_OUT  = 4'd14;

	logic [3:0] state_q;

	// configuration
	logic [11:0] center_x_q, center_y_q, scale_q, max_q;
	logic [15:0] ratio_q;
	logic [4:0]  count_q;

	// per-render values
	logic [11:0]      lx_q, ly_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] idx_q;
	logic [12:0]      corner_q, ldist_q;
	logic [12:0]      falloff;
	logic [24:0]      fs_q;

	// per-element values
	logic [40:0]        prod_w_q;
	logic [20:0]        fa_q;
	logic [15:0]        d_q;
	logic [23:0]        rgb_q;
	logic [2:0]         tex_q;
	logic signed [17:0] px_q, py_q;
	logic [11:0]        wid_q;
	logic [7:0]         alpha_q;
	logic [15:0]        height_q;

	logic      out_valid_q;
	out_item_t out_q;

	// element table
	logic [GEO_W-1:0]  rgeo;
	logic [LOOK_W-1:0] rlook;
	logic              load_we;

	assign in_ready = (state_q == S_IDLE);
	assign load_we  = in_valid && in_ready && (in_data.kind == KIND_LOAD)
		&& (int'(in_data.element_index) < ELEM_DEPTH);

	lfsp_elem_mem u_mem (
		.clk   (clk),
		.we    (load_we),
		.waddr (ELEM_AW'(in_data.element_index)),
		.wgeo  ({in_data.element_distance, in_data.element_size}),
		.wlook ({in_data.element_texture, in_data.element_colour}),
		.re    (state_q == S_RD),
		.raddr (idx_q[ELEM_AW-1:0]),
		.rgeo  (rgeo),
		.rlook (rlook)
	);

	// shared square root: corner distance first, then light distance
	logic [11:0]         dxl, dyl;
	logic [SQ_IN_W-1:0]  sq_value;
	logic                sq_start;
	logic [SQ_OUT_W-1:0] sq_root;
	logic                sq_done;

	assign dxl = (lx_q > center_x_q) ? lx_q - center_x_q : center_x_q - lx_q;
	assign dyl = (ly_q > center_y_q) ? ly_q - center_y_q : center_y_q - ly_q;

	always_comb begin
		if (state_q == S_SQC)
			sq_value = SQ_IN_W'(24'(center_x_q * center_x_q))
				+ SQ_IN_W'(24'(center_y_q * center_y_q));
		else
			sq_value = SQ_IN_W'(24'(dxl * dxl)) + SQ_IN_W'(24'(dyl * dyl));
	end
	assign sq_start = (state_q == S_SQC) || (state_q == S_SQL);

	lfsp_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (sq_value),
		.root   (sq_root),
		.done   (sq_done)
	);

	// width and alpha dividers run side by side
	logic              div_start;
	logic [DIV_NW-1:0] wdiv_quo, adiv_quo;
	logic              wdiv_done, adiv_done;

	assign div_start = (state_q == S_M3) && (corner_q != '0);

	lfsp_div u_wdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_w_q[40:15]),
		.den    (corner_q),
		.quo    (wdiv_quo),
		.done   (wdiv_done)
	);

	lfsp_div u_adiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (DIV_NW'(fa_q)),
		.den    (corner_q),
		.quo    (adiv_quo),
		.done   (adiv_done)
	);

	// position: trunc(((l<<15) + 2d(c-l)) / 32768) toward zero; x in S_M2, y in S_M3
	logic [11:0]        pos_l, pos_c;
	logic signed [12:0] pos_diff;
	logic signed [29:0] pos_prod;
	logic signed [32:0] pos_num, pos_adj;

	always_comb begin
		pos_l    = (state_q == S_M2) ? lx_q : ly_q;
		pos_c    = (state_q == S_M2) ? center_x_q : center_y_q;
		pos_diff = $signed({1'b0, pos_c}) - $signed({1'b0, pos_l});
		pos_prod = 30'($signed({1'b0, d_q}) * pos_diff);
		pos_num  = $signed({6'b0, pos_l, 15'b0})
			+ $signed({{2{pos_prod[29]}}, pos_prod, 1'b0});
		pos_adj  = pos_num + (pos_num[32] ? 33'sd32767 : 33'sd0);
	end

	// height and edge offsets
	logic [27:0]        h_prod;
	logic signed [18:0] x_edge, y_edge;
	logic signed [15:0] x_sat, y_sat;

	assign h_prod = wid_q * ratio_q;
	assign x_edge = $signed({px_q[17], px_q}) - $signed({8'b0, wid_q[11:1]});
	assign y_edge = $signed({py_q[17], py_q}) - $signed({4'b0, height_q[15:1]});

	always_comb begin
		if (x_edge > 19'sd32767)
			x_sat = 16'sh7fff;
		else if (x_edge < -19'sd32768)
			x_sat = 16'sh8000;
		else
			x_sat = x_edge[15:0];
		if (y_edge > 19'sd32767)
			y_sat = 16'sh7fff;
		else if (y_edge < -19'sd32768)
			y_sat = 16'sh8000;
		else
			y_sat = y_edge[15:0];
	end

	// configuration writes; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= RST_CENTER_X;
			center_y_q <= RST_CENTER_Y;
			scale_q    <= RST_SCALE_PX;
			max_q      <= RST_MAX_PX;
			ratio_q    <= RST_HEIGHT;
			count_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X:   center_x_q <= cfg_wdata[11:0];
				REG_CENTER_Y:   center_y_q <= cfg_wdata[11:0];
				REG_SCALE_PX:   scale_q    <= cfg_wdata[11:0];
				REG_MAX_PX:     max_q      <= cfg_wdata[11:0];
				REG_HEIGHT_RAT: ratio_q    <= cfg_wdata;
				REG_ELEM_COUNT: count_q    <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			n_q         <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_data.kind == KIND_RENDER) begin
						idx_q <= '0;
						// saturate the element count to the table depth
						n_q <= (int'(count_q) > ELEM_DEPTH) ? CNT_W'(ELEM_DEPTH)
							: CNT_W'(count_q);
						state_q <= S_SQC;
					end
				end
				S_SQC: state_q <= S_RTC;
				S_RTC: if (sq_done) state_q <= S_SQL;
				S_SQL: state_q <= S_RTL;
				S_RTL: if (sq_done) state_q <= S_FS;
				S_FS:  state_q <= (n_q == '0) ? S_IDLE : S_RD;
				S_RD:  state_q <= S_M1;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= (corner_q == '0) ? S_WID : S_DIV;
				S_DIV: if (wdiv_done) state_q <= S_WID;
				S_WID: state_q <= S_HGT;
				S_HGT: state_q <= S_FORM;
				S_FORM: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (idx_q + 1'b1 == n_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			lx_q <= in_data.light_x;
			ly_q <= in_data.light_y;
		end
		if (state_q == S_RTC && sq_done)
			corner_q <= sq_root;
		if (state_q == S_RTL && sq_done)
			ldist_q <= sq_root;
		if (state_q == S_FS)
			fs_q <= falloff * scale_q;
		if (state_q == S_M1) begin
			prod_w_q <= fs_q * rgeo[15:0];
			fa_q     <= falloff * rlook[31:24];
			d_q      <= rgeo[31:16];
			rgb_q    <= rlook[23:0];
			tex_q    <= rlook[34:32];
		end
		if (state_q == S_M2)
			px_q <= pos_adj[32:15];
		if (state_q == S_M3)
			py_q <= pos_adj[32:15];
		if (state_q == S_WID) begin
			// zero corner distance: nothing drawn
			if (corner_q == '0)
				wid_q <= '0;
			else if (wdiv_quo > DIV_NW'(max_q))
				wid_q <= max_q;
			else
				wid_q <= wdiv_quo[11:0];
			if (corner_q == '0)
				alpha_q <= '0;
			else if (|adiv_quo[DIV_NW-1:8])
				alpha_q <= 8'hff;
			else
				alpha_q <= adiv_quo[7:0];
		end
		if (state_q == S_HGT)
			height_q <= (|h_prod[27:24]) ? 16'hffff : h_prod[23:8];
		if (state_q == S_FORM) begin
			out_q.quad_x       <= x_sat;
			out_q.quad_y       <= y_sat;
			out_q.quad_width   <= wid_q;
			out_q.quad_height  <= height_q;
			out_q.quad_colour  <= {alpha_q, rgb_q};
			out_q.quad_texture <= tex_q;
			out_q.drawn        <= wid_q > 12'd1;
			out_q.last         <= (idx_q + 1'b1 == n_q);
		end
	end

	// falloff: corner distance less light distance, floored at zero
	always_comb falloff = (corner_q > ldist_q) ? corner_q - ldist_q : '0;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_valid_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT)
		else $error("result shown outside the output state");
	a_render_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.kind == KIND_RENDER |=> state_q == S_SQC)
		else $error("render transfer did not start the sequencer");
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last |=> state_q == S_IDLE)
		else $error("sequencer did not stop after the final element");
	a_width_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.quad_width <= max_q)
		else $error("width above the configured maximum");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> idx_q < n_q)
		else $error("element read beyond the count in use");
	a_div_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		wdiv_done == adiv_done)
		else $error("width and alpha dividers out of step");
`endif

endmodule

// ===== rtl/lfsp_elem_mem.sv =====
// Element table: geometry and look memories, one write and one read port.
// Depends on lfsp_pkg for depth and word widths.
module lfsp_elem_mem (
	input  logic                        clk,
	input  logic                        we,
	input  logic [lfsp_pkg::ELEM_AW-1:0] waddr,
	input  logic [lfsp_pkg::GEO_W-1:0]  wgeo,
	input  logic [lfsp_pkg::LOOK_W-1:0] wlook,
	input  logic                        re,
	input  logic [lfsp_pkg::ELEM_AW-1:0] raddr,
	output logic [lfsp_pkg::GEO_W-1:0]  rgeo,
	output logic [lfsp_pkg::LOOK_W-1:0] rlook
);
	import lfsp_pkg::*;

	logic [GEO_W-1:0]  geo_mem  [ELEM_DEPTH];
	logic [LOOK_W-1:0] look_mem [ELEM_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			geo_mem[waddr]  <= wgeo;
			look_mem[waddr] <= wlook;
		end
	end

	// registered read; data appears in the cycle after re
	always_ff @(posedge clk) begin
		if (re) begin
			rgeo  <= geo_mem[raddr];
			rlook <= look_mem[raddr];
		end
	end

endmodule

// ===== rtl/lfsp_isqrt.sv =====
// Floor square root, two radicand bits per cycle.
// Depends on lfsp_pkg for widths and step count.
module lfsp_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lfsp_pkg::SQ_IN_W-1:0] value,
	output logic [lfsp_pkg::SQ_OUT_W-1:0] root,
	output logic                         done
);
	import lfsp_pkg::*;

	localparam int SC_W = $clog2(SQ_STEPS);

	logic                busy_q;
	logic                done_q;
	logic [SC_W-1:0]     cnt_q;
	logic [SQ_IN_W-1:0]  val_q;
	logic [SQ_OUT_W+2:0] rem_q;
	logic [SQ_OUT_W-1:0] root_q;
	logic [SQ_OUT_W+2:0] rem_n;
	logic [SQ_OUT_W+2:0] trial;
	logic                ge;

	assign rem_n = {rem_q[SQ_OUT_W:0], val_q[SQ_IN_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == SC_W'(SQ_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SC_W'(SQ_STEPS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= val_q << 2;
			rem_q  <= ge ? rem_n - trial : rem_n;
			root_q <= {root_q[SQ_OUT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ===== rtl/lfsp_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lfsp_pkg for operand widths.
module lfsp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lfsp_pkg::DIV_NW-1:0] num,
	input  logic [lfsp_pkg::DIV_DW-1:0] den,
	output logic [lfsp_pkg::DIV_NW-1:0] quo,
	output logic                        done
);
	import lfsp_pkg::*;

	localparam int DC_W = $clog2(DIV_NW);

	logic              busy_q;
	logic              done_q;
	logic [DC_W-1:0]   cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW:0]   rem_n;
	logic              ge;

	assign rem_n = {rem_q, quo_q[DIV_NW-1]};
	assign ge    = rem_n >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DC_W'(DIV_NW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DC_W'(DIV_NW - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// numerator shifts out the top while quotient bits enter the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DW'(rem_n - {1'b0, den_q}) : rem_n[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule
